// ===== rtl/msb_first_bit_packer_with_stuffing_top_macros.svh =====
// assertion macros for the bit packer checker
`ifndef MSB_FIRST_BIT_PACKER_WITH_STUFFING_TOP_MACROS_SVH
`define MSB_FIRST_BIT_PACKER_WITH_STUFFING_TOP_MACROS_SVH

// implication into the next cycle, disabled during reset
`define MFBP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mfbp assertion failed");

// implication into the next cycle, checked during reset as well
`define MFBP_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mfbp assertion failed");

`endif

// ===== rtl/mfbp_pkg.sv =====
// shared types and constants of the msb first bit packer
`default_nettype none
package mfbp_pkg;

  localparam int unsigned LEN_W   = 6;
  localparam int unsigned CODE_W  = 32;
  localparam int unsigned MB_W    = 9;
  localparam int unsigned QP_W    = 5;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned MAX_BYTES = 5;
  localparam int unsigned BUF_W   = MAX_BYTES * BYTE_W;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned SLICE_W = 33;

  localparam logic [LEN_W-1:0] MAX_CODE_LEN = 6'd32;
  localparam logic [LEN_W-1:0] SLICE_LEN    = 6'd33;

  localparam logic FUNC_CODE  = 1'b0;
  localparam logic FUNC_SLICE = 1'b1;

  typedef struct packed {
    logic              func;
    logic [LEN_W-1:0]  code_length;
    logic [CODE_W-1:0] code_bits;
    logic              end_of_stream;
    logic [MB_W-1:0]   macroblock_number;
    logic [QP_W-1:0]   quant_param;
  } item_t;

  typedef struct packed {
    logic [BUF_W-1:0] bytes;
    logic [CNT_W-1:0] count;
  } pack_res_t;

endpackage
`default_nettype wire

// ===== rtl/mfbp_in_reg.sv =====
// input register stage holding one accepted item
`default_nettype none
module mfbp_in_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire mfbp_pkg::item_t in_item,
  output logic               held_valid,
  output mfbp_pkg::item_t    held_item,
  input  wire logic          advance
);

  logic held;

  assign in_ready   = !held || advance;
  assign held_valid = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (advance) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mfbp_pack.sv =====
// packing logic and pending byte state
`default_nettype none
module mfbp_pack (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire mfbp_pkg::item_t item,
  input  wire logic            commit,
  output mfbp_pkg::pack_res_t  res
);

  localparam int unsigned WIDE_W = mfbp_pkg::BUF_W + mfbp_pkg::BYTE_W;

  logic [mfbp_pkg::BYTE_W-1:0] pend;
  logic [mfbp_pkg::CNT_W-1:0]  pend_cnt;
  logic [mfbp_pkg::BYTE_W-1:0] pend_next;
  logic [mfbp_pkg::CNT_W-1:0]  pend_cnt_next;

  logic [mfbp_pkg::LEN_W-1:0]   len_c;
  logic [mfbp_pkg::LEN_W-1:0]   len_t;
  logic [mfbp_pkg::LEN_W-1:0]   total;
  logic [mfbp_pkg::CODE_W-1:0]  code_left;
  logic [15:0]                  info;
  logic [mfbp_pkg::SLICE_W-1:0] slice_word;
  logic [WIDE_W-1:0]            src;
  logic [WIDE_W-1:0]            bits;
  logic [WIDE_W-1:0]            stuffed;
  logic [WIDE_W-1:0]            cur_sh;
  logic [mfbp_pkg::CNT_W-1:0]   full_bytes;
  logic [mfbp_pkg::CNT_W-1:0]   rem;
  logic [mfbp_pkg::BYTE_W-1:0]  fill;
  logic                         eos;

  always_comb begin
    len_c = (item.code_length > mfbp_pkg::MAX_CODE_LEN) ? mfbp_pkg::MAX_CODE_LEN
                                                         : item.code_length;
    code_left = item.code_bits << (mfbp_pkg::MAX_CODE_LEN - len_c);
    info = {item.macroblock_number, 7'b0} + {9'b0, item.quant_param, 2'b0};
    slice_word[0] = 1'b1;
    for (int i = 0; i < 16; i++) begin
      slice_word[mfbp_pkg::SLICE_W-1-2*i] = 1'b0;
      slice_word[mfbp_pkg::SLICE_W-2-2*i] = info[15-i];
    end
    if (item.func == mfbp_pkg::FUNC_SLICE) begin
      len_t = mfbp_pkg::SLICE_LEN;
      eos   = 1'b0;
      src   = {slice_word, {(WIDE_W-mfbp_pkg::SLICE_W){1'b0}}};
    end else begin
      len_t = len_c;
      eos   = item.end_of_stream;
      src   = {code_left, {(WIDE_W-mfbp_pkg::CODE_W){1'b0}}};
    end
    bits       = {pend, {mfbp_pkg::BUF_W{1'b0}}} | (src >> pend_cnt);
    total      = {{(mfbp_pkg::LEN_W-mfbp_pkg::CNT_W){1'b0}}, pend_cnt} + len_t;
    full_bytes = total[mfbp_pkg::LEN_W-1:3];
    rem        = total[2:0];
    // zero then ones, a lone free position gets a one
    fill = (rem == 3'd7) ? 8'h01 : (8'hFF >> ({1'b0, rem} + 4'd1));
    stuffed = bits | ({fill, {mfbp_pkg::BUF_W{1'b0}}} >> {full_bytes, 3'b0});
    cur_sh  = bits << {full_bytes, 3'b0};
    if (eos) begin
      res.bytes     = stuffed[WIDE_W-1:mfbp_pkg::BYTE_W];
      res.count     = full_bytes + 3'd1;
      pend_next     = '0;
      pend_cnt_next = '0;
    end else begin
      res.bytes     = bits[WIDE_W-1:mfbp_pkg::BYTE_W];
      res.count     = full_bytes;
      pend_next     = cur_sh[WIDE_W-1:mfbp_pkg::BUF_W];
      pend_cnt_next = rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend     <= '0;
      pend_cnt <= '0;
    end else if (commit) begin
      pend     <= pend_next;
      pend_cnt <= pend_cnt_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mfbp_out_buf.sv =====
// output byte buffer that drains one byte per transfer
`default_nettype none
module mfbp_out_buf (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          load,
  input  wire mfbp_pkg::pack_res_t           load_res,
  output logic                               can_load,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [mfbp_pkg::BYTE_W-1:0]        out_byte,
  output logic                               out_last
);

  logic [mfbp_pkg::BUF_W-1:0] data;
  logic [mfbp_pkg::CNT_W-1:0] count;

  assign out_valid = (count != '0);
  assign out_last  = (count == 3'd1);
  assign out_byte  = data[mfbp_pkg::BUF_W-1 -: mfbp_pkg::BYTE_W];
  assign can_load  = (count == '0) || (out_last && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= load_res.count;
    end else if (out_valid && out_ready) begin
      count <= count - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_res.bytes;
    end else if (out_valid && out_ready) begin
      data <= data << mfbp_pkg::BYTE_W;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/msb_first_bit_packer_with_stuffing_top.sv =====
// top level of the msb first bit packer with end of stream stuffing
//
//   channel  dir  payload
//   s_*      in   tdata: code_length, code_bits, macroblock_number, quant_param;
//                 tuser: func; tlast: end_of_stream
//   m_*      out  tdata: out_byte; tlast: last_byte
//
// an accepted item waits in the input register until it can advance, then is packed
// into the output buffer, giving 0 to 5 bytes, one per output transfer
// the byte buffer sets the item rate: it takes the next item while the last byte is in transfer
// an item that yields no byte only updates the pending bits and never waits on output
// rst synchronously clears the pending bits, the input register and the output buffer
// output stalls hold the current byte; input is taken while the last byte is in transfer
`default_nettype none
module msb_first_bit_packer_with_stuffing_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [5:0] code_length, [37:6] code_bits, [46:38] macroblock_number,
  // [51:47] quant_param, [55:52] zero
  input  wire logic [55:0] s_tdata,
  // [0] func
  input  wire logic [0:0]  s_tuser,
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [7:0] out_byte
  output logic [7:0]       m_tdata,
  output logic             m_tlast
);

  mfbp_pkg::item_t     in_item;
  mfbp_pkg::item_t     held_item;
  mfbp_pkg::pack_res_t res;
  logic                held_valid;
  logic                can_load;
  logic                advance;
  logic                load;

  always_comb begin
    in_item.func              = s_tuser[0];
    in_item.code_length       = s_tdata[5:0];
    in_item.code_bits         = s_tdata[37:6];
    in_item.end_of_stream     = s_tlast;
    in_item.macroblock_number = s_tdata[46:38];
    in_item.quant_param       = s_tdata[51:47];
  end

  assign advance = held_valid && ((res.count == '0) || can_load);
  assign load    = advance && (res.count != '0);

  mfbp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .held_valid (held_valid),
    .held_item  (held_item),
    .advance    (advance)
  );

  mfbp_pack u_pack (
    .clk    (clk),
    .rst    (rst),
    .item   (held_item),
    .commit (advance),
    .res    (res)
  );

  mfbp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .load_res  (res),
    .can_load  (can_load),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule
`default_nettype wire

// ===== rtl/mfbp_checker.sv =====
// port level checks of the bit packer and their binding
`default_nettype none
`include "msb_first_bit_packer_with_stuffing_top_macros.svh"
module mfbp_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast
);

  // stalled output holds
  `MFBP_ASSERT_NEXT(a_stall_valid, clk, rst, m_tvalid && !m_tready, m_tvalid)
  `MFBP_ASSERT_NEXT(a_stall_data, clk, rst, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))
  // bytes of one item follow each other without a gap
  `MFBP_ASSERT_NEXT(a_burst_cont, clk, rst, m_tvalid && m_tready && !m_tlast, m_tvalid)
  // reset empties the output buffer
  `MFBP_ASSERT_ALWAYS(a_reset_empty, clk, rst, !m_tvalid)

endmodule

bind msb_first_bit_packer_with_stuffing_top mfbp_checker u_mfbp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
`default_nettype wire
